>>> hdl/psa_pkg.sv
// Shared types, operation codes and the lane operation for the packed SIMD ALU.
package psa_pkg;

    typedef enum logic [4:0] {
        OP_ORR     = 5'd0,
        OP_AND     = 5'd1,
        OP_ADD     = 5'd2,
        OP_SUB     = 5'd3,
        OP_UMIN    = 5'd4,
        OP_SMIN    = 5'd5,
        OP_UMAX    = 5'd6,
        OP_SMAX    = 5'd7,
        OP_CMEQ    = 5'd8,
        OP_CMGT    = 5'd9,
        OP_CMGE    = 5'd10,
        OP_CMTST   = 5'd11,
        OP_CMEQI   = 5'd12,
        OP_CMLTI   = 5'd13,
        OP_CMLEI   = 5'd14,
        OP_CMGTI   = 5'd15,
        OP_CMGEI   = 5'd16,
        OP_ADDP    = 5'd17,
        OP_UMAXP   = 5'd18,
        OP_SMAXP   = 5'd19,
        OP_UMINP   = 5'd20,
        OP_SMINP   = 5'd21,
        OP_DUP     = 5'd22,
        OP_UMOV_HI = 5'd23,
        OP_INS_HI  = 5'd24
    } t_op;

    localparam logic [1:0] LS_8  = 2'd0;
    localparam logic [1:0] LS_16 = 2'd1;
    localparam logic [1:0] LS_32 = 2'd2;
    localparam logic [1:0] LS_64 = 2'd3;

    typedef struct packed {
        t_op         req_type;
        logic [1:0]  lane_size;
        logic        full_width;
        logic [63:0] first_low;
        logic [63:0] first_high;
        logic [63:0] second_low;
        logic [63:0] second_high;
        logic [63:0] scalar_value;
        logic [63:0] compare_imm;
    } t_req;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic        bad_combination;
    } t_rsp;

    // One lane, operands zero-extended to 64 bits; ls picks the lane width.
    function automatic logic [63:0] lane_op(input t_op op, input logic [1:0] ls,
                                            input logic [63:0] a, input logic [63:0] b);
        logic [63:0] m;
        logic [63:0] sb;
        logic [63:0] sa;
        logic [63:0] sv;
        logic        t;
        logic [63:0] r;
        case (ls)
            LS_8:    m = 64'h0000_0000_0000_00FF;
            LS_16:   m = 64'h0000_0000_0000_FFFF;
            LS_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        sb = m ^ (m >> 1);
        // flip the sign bit so unsigned compares give signed order
        sa = a ^ sb;
        sv = b ^ sb;
        t  = 1'b0;
        r  = 64'd0;
        case (op)
            OP_ORR:              r = a | b;
            OP_AND:              r = a & b;
            OP_ADD:              r = (a + b) & m;
            OP_SUB:              r = (a - b) & m;
            OP_UMIN:             r = (a < b) ? a : b;
            OP_SMIN:             r = (sa < sv) ? a : b;
            OP_UMAX:             r = (a < b) ? b : a;
            OP_SMAX:             r = (sa < sv) ? b : a;
            OP_CMEQ, OP_CMEQI:   t = (a == b);
            OP_CMGT, OP_CMGTI:   t = (sa > sv);
            OP_CMGE, OP_CMGEI:   t = (sa >= sv);
            OP_CMTST:            t = ((a & b) != 64'd0);
            OP_CMLTI:            t = (sa < sv);
            OP_CMLEI:            t = (sa <= sv);
            default:             r = 64'd0;
        endcase
        if (t) begin
            r = m;
        end
        return r;
    endfunction

endpackage

>>> hdl/psa_req_if.sv
// Request channel: operation, lane size and operand words.
interface psa_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  req_type;
    logic [1:0]  lane_size;
    logic        full_width;
    logic [63:0] first_low;
    logic [63:0] first_high;
    logic [63:0] second_low;
    logic [63:0] second_high;
    logic [63:0] scalar_value;
    logic [63:0] compare_imm;

    modport source (
        output valid, req_type, lane_size, full_width, first_low, first_high,
               second_low, second_high, scalar_value, compare_imm,
        input  ready
    );

    modport sink (
        input  valid, req_type, lane_size, full_width, first_low, first_high,
               second_low, second_high, scalar_value, compare_imm,
        output ready
    );
endinterface

>>> hdl/psa_rsp_if.sv
// Response channel: result vector and unsupported-combination flag.
interface psa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        bad_combination;

    modport source (
        output valid, result_low, result_high, bad_combination,
        input  ready
    );

    modport sink (
        input  valid, result_low, result_high, bad_combination,
        output ready
    );
endinterface

>>> hdl/psa_exec.sv
// Combinational datapath: operand routing, lane ALUs for every lane width, result select.
module psa_exec (
    input  psa_pkg::t_req i_req,
    output psa_pkg::t_rsp o_rsp
);
    import psa_pkg::*;

    logic [127:0] vec_a;
    logic [127:0] vec_b;
    logic         is_pair;
    logic         is_imm;
    logic         is_minmax;
    t_op          base_op;
    wire  [127:0] lane_res [4];
    wire  [127:0] dup_vec  [4];
    logic [127:0] lane_sel;
    logic [127:0] dup_sel;
    logic [127:0] res;
    logic         bad;

    // 64-bit forms see zero in the upper operand halves
    assign vec_a = {i_req.full_width ? i_req.first_high : 64'd0, i_req.first_low};
    assign vec_b = {i_req.full_width ? i_req.second_high : 64'd0, i_req.second_low};

    always_comb begin
        is_pair = (i_req.req_type == OP_ADDP) || (i_req.req_type == OP_UMAXP) ||
                  (i_req.req_type == OP_SMAXP) || (i_req.req_type == OP_UMINP) ||
                  (i_req.req_type == OP_SMINP);
        is_imm  = (i_req.req_type == OP_CMEQI) || (i_req.req_type == OP_CMLTI) ||
                  (i_req.req_type == OP_CMLEI) || (i_req.req_type == OP_CMGTI) ||
                  (i_req.req_type == OP_CMGEI);
        is_minmax = (i_req.req_type == OP_UMIN) || (i_req.req_type == OP_SMIN) ||
                    (i_req.req_type == OP_UMAX) || (i_req.req_type == OP_SMAX) ||
                    (i_req.req_type == OP_UMAXP) || (i_req.req_type == OP_SMAXP) ||
                    (i_req.req_type == OP_UMINP) || (i_req.req_type == OP_SMINP);
        case (i_req.req_type)
            OP_ADDP:  base_op = OP_ADD;
            OP_UMAXP: base_op = OP_UMAX;
            OP_SMAXP: base_op = OP_SMAX;
            OP_UMINP: base_op = OP_UMIN;
            OP_SMINP: base_op = OP_SMIN;
            default:  base_op = i_req.req_type;
        endcase
    end

    for (genvar s = 0; s < 4; s++) begin : g_size
        localparam int W  = 8 << s;
        localparam int N  = 128 / W;
        localparam int HF = 64 / W;
        localparam int HH = 32 / W;

        wire  [127:0] pair_a_full;
        wire  [127:0] pair_b_full;
        wire  [127:0] pair_a_half;
        wire  [127:0] pair_b_half;
        logic [127:0] elem_b;
        logic [127:0] opa;
        logic [127:0] opb;

        assign elem_b     = is_imm ? {N{i_req.compare_imm[W-1:0]}} : vec_b;
        assign dup_vec[s] = {N{i_req.scalar_value[W-1:0]}};

        for (genvar j = 0; j < N; j++) begin : g_lane
            logic [63:0] lres;

            // 128-bit pairwise: low half from first vector, high half from second
            if (j < HF) begin : g_full_a
                assign pair_a_full[j*W +: W] = vec_a[2*j*W +: W];
                assign pair_b_full[j*W +: W] = vec_a[(2*j+1)*W +: W];
            end else begin : g_full_b
                assign pair_a_full[j*W +: W] = vec_b[2*(j-HF)*W +: W];
                assign pair_b_full[j*W +: W] = vec_b[(2*(j-HF)+1)*W +: W];
            end

            // 64-bit pairwise: quarters of the vector, upper half dropped later
            if (j < HH) begin : g_half_a
                assign pair_a_half[j*W +: W] = vec_a[2*j*W +: W];
                assign pair_b_half[j*W +: W] = vec_a[(2*j+1)*W +: W];
            end else if (j < 2*HH) begin : g_half_b
                assign pair_a_half[j*W +: W] = vec_b[2*(j-HH)*W +: W];
                assign pair_b_half[j*W +: W] = vec_b[(2*(j-HH)+1)*W +: W];
            end else begin : g_half_z
                assign pair_a_half[j*W +: W] = '0;
                assign pair_b_half[j*W +: W] = '0;
            end

            assign lres = lane_op(base_op, 2'(s), 64'(opa[j*W +: W]), 64'(opb[j*W +: W]));
            assign lane_res[s][j*W +: W] = lres[W-1:0];
        end

        always_comb begin
            if (is_pair) begin
                opa = i_req.full_width ? pair_a_full : pair_a_half;
                opb = i_req.full_width ? pair_b_full : pair_b_half;
            end else begin
                opa = vec_a;
                opb = elem_b;
            end
        end
    end

    always_comb begin
        lane_sel = lane_res[i_req.lane_size];
        dup_sel  = dup_vec[i_req.lane_size];
        bad      = 1'b0;
        res      = 128'd0;
        if (i_req.lane_size == LS_64 && is_minmax) begin
            bad = 1'b1;
        end else begin
            case (i_req.req_type)
                OP_ORR, OP_AND, OP_ADD, OP_SUB, OP_UMIN, OP_SMIN, OP_UMAX, OP_SMAX,
                OP_CMEQ, OP_CMGT, OP_CMGE, OP_CMTST, OP_CMEQI, OP_CMLTI, OP_CMLEI,
                OP_CMGTI, OP_CMGEI, OP_ADDP, OP_UMAXP, OP_SMAXP, OP_UMINP,
                OP_SMINP: begin
                    // a single 64-bit lane has no pair
                    if (is_pair && i_req.lane_size == LS_64 && !i_req.full_width) begin
                        bad = 1'b1;
                    end else begin
                        res = lane_sel;
                    end
                end
                OP_DUP:     res = dup_sel;
                OP_UMOV_HI: res = {64'd0, i_req.first_high};
                OP_INS_HI:  res = {i_req.scalar_value, i_req.first_low};
                default:    bad = 1'b1;
            endcase
        end
        if (!i_req.full_width && i_req.req_type != OP_INS_HI) begin
            res[127:64] = 64'd0;
        end
    end

    assign o_rsp.result_low      = res[63:0];
    assign o_rsp.result_high     = res[127:64];
    assign o_rsp.bad_combination = bad;

endmodule

>>> hdl/packed_simd_integer_alu_core.sv
// Packed integer SIMD ALU: request and result registers around the lane datapath.
//
// Usage:
//   i_req carries one operation word: req_type, lane_size, full_width, two
//   128-bit vectors split in halves, a general-register value and a compare
//   immediate. o_rsp returns result_low, result_high and bad_combination.
//   A word moves on either channel when valid and ready are both high.
//   An accepted word sits in the request register while the lane ALUs evaluate
//   it, then moves into the result register, which drives o_rsp.valid.
//   Throughput is one word per cycle while o_rsp.ready stays high; the lane
//   datapath evaluates all lane widths in parallel and is combinational.
//   When the receiver holds o_rsp.ready low, the result register holds its
//   word, the request register fills behind it, and i_req.ready drops only
//   once both are full. Up to two words are held in flight.
//   Reset (i_rst_n low at a clock edge) empties both registers; no result is
//   presented until a new word has been accepted. There is no other state.
module packed_simd_integer_alu_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psa_req_if.sink    i_req,
    psa_rsp_if.source  o_rsp
);
    import psa_pkg::*;

    logic r_s1_valid;
    logic n_s1_valid;
    t_req r_s1_req;
    logic r_s2_valid;
    logic n_s2_valid;
    t_rsp r_s2_rsp;
    t_rsp exec_rsp;
    logic s2_take;
    logic in_take;

    assign s2_take     = !r_s2_valid || o_rsp.ready;
    assign in_take     = !r_s1_valid || s2_take;
    assign i_req.ready = in_take;

    always_comb begin
        n_s1_valid = in_take ? i_req.valid : r_s1_valid;
        n_s2_valid = s2_take ? r_s1_valid : r_s2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_req.valid) begin
            r_s1_req.req_type     <= t_op'(i_req.req_type);
            r_s1_req.lane_size    <= i_req.lane_size;
            r_s1_req.full_width   <= i_req.full_width;
            r_s1_req.first_low    <= i_req.first_low;
            r_s1_req.first_high   <= i_req.first_high;
            r_s1_req.second_low   <= i_req.second_low;
            r_s1_req.second_high  <= i_req.second_high;
            r_s1_req.scalar_value <= i_req.scalar_value;
            r_s1_req.compare_imm  <= i_req.compare_imm;
        end
        // advance the computed word only into an empty or draining slot
        if (s2_take && r_s1_valid) begin
            r_s2_rsp <= exec_rsp;
        end
    end

    psa_exec u_exec (
        .i_req (r_s1_req),
        .o_rsp (exec_rsp)
    );

    assign o_rsp.valid           = r_s2_valid;
    assign o_rsp.result_low      = r_s2_rsp.result_low;
    assign o_rsp.result_high     = r_s2_rsp.result_high;
    assign o_rsp.bad_combination = r_s2_rsp.bad_combination;

`ifndef ASSERT_OFF
    a_bad_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.bad_combination |->
            o_rsp.result_low == 64'd0 && o_rsp.result_high == 64'd0)
        else $error("unsupported combination returned a nonzero result");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s2_valid && !o_rsp.ready |-> !i_req.ready)
        else $error("request accepted while both registers are full and stalled");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_s1_valid)
        else $error("accepted word lost before the request register");

    a_s1_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s2_valid |=> r_s2_valid)
        else $error("request word did not advance into an empty result register");
`endif

endmodule

>>> dv/packed_simd_integer_alu_core_test.sv
// Self-checking bench for the packed SIMD ALU: random and directed words, lane-level predictor.
module packed_simd_integer_alu_core_test;
    import psa_pkg::*;

    localparam logic [4:0] CODE_MAX    = 5'h1F;
    localparam int         RANDOM_WORDS = 1225;
    localparam int         HOLD_AT      = 300;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [4:0]  code;
        logic [1:0]  lsz;
        logic        wide;
        logic [63:0] a_lo;
        logic [63:0] a_hi;
        logic [63:0] b_lo;
        logic [63:0] b_hi;
        logic [63:0] gp;
        logic [63:0] imm;
    } t_simd_word;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        bad;
    } t_simd_result;

    logic clk = 1'b0;
    logic rst_n;

    psa_req_if req_ch ();
    psa_rsp_if rsp_ch ();

    packed_simd_integer_alu_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_simd_word   pending_words[$];
    t_simd_result expected_results[$];
    t_simd_word   offered_word;
    t_simd_result want;
    int           total_words;
    int           words_accepted;
    int           results_seen;
    int           mismatches;
    int           send_gap;
    int           send_calm;
    int           recv_stall;
    int           recv_calm;
    int           idle_cycles;
    int           g;
    logic         hold_done;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] lane_mask_of(input int unsigned w);
        return (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    // One lane of width w; a and b already hold only the lane bits.
    function automatic logic [63:0] lane_eval(input logic [4:0] op, input int unsigned w,
                                              input logic [63:0] a, input logic [63:0] b);
        logic [63:0] m;
        logic [63:0] sgn;
        logic [63:0] sa;
        logic [63:0] sb;
        logic        hit;
        m   = lane_mask_of(w);
        sgn = 64'd1 << (w - 1);
        // offset by the sign bit so an unsigned compare orders signed lanes
        sa  = a ^ sgn;
        sb  = b ^ sgn;
        hit = 1'b0;
        case (op)
            OP_ORR:            return a | b;
            OP_AND:            return a & b;
            OP_ADD:            return (a + b) & m;
            OP_SUB:            return (a - b) & m;
            OP_UMIN:           return (a < b) ? a : b;
            OP_SMIN:           return (sa < sb) ? a : b;
            OP_UMAX:           return (a < b) ? b : a;
            OP_SMAX:           return (sa < sb) ? b : a;
            OP_CMEQ, OP_CMEQI: hit = (a == b);
            OP_CMGT, OP_CMGTI: hit = (sa > sb);
            OP_CMGE, OP_CMGEI: hit = (sa >= sb);
            OP_CMTST:          hit = ((a & b) != 64'd0);
            OP_CMLTI:          hit = (sa < sb);
            OP_CMLEI:          hit = (sa <= sb);
            default:           return 64'd0;
        endcase
        return hit ? m : 64'd0;
    endfunction

    function automatic t_simd_result vector_alu_predict(input t_simd_word wd);
        t_simd_result r;
        logic [127:0] va;
        logic [127:0] vb;
        logic [127:0] vr;
        logic [63:0]  m;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [4:0]   base;
        int unsigned  w;
        int unsigned  n;
        int unsigned  half;
        w     = 8 << wd.lsz;
        n     = (wd.wide ? 128 : 64) / w;
        m     = lane_mask_of(w);
        va    = {wd.wide ? wd.a_hi : 64'd0, wd.a_lo};
        vb    = {wd.wide ? wd.b_hi : 64'd0, wd.b_lo};
        vr    = '0;
        r.bad = 1'b0;
        if (wd.lsz == LS_64 && ((wd.code >= OP_UMIN && wd.code <= OP_SMAX) ||
                                (wd.code >= OP_UMAXP && wd.code <= OP_SMINP))) begin
            r.bad = 1'b1;
        end else if (wd.code <= OP_CMGEI) begin
            for (int i = 0; i < n; i++) begin
                x  = 64'(va >> (i * w)) & m;
                y  = (wd.code >= OP_CMEQI) ? (wd.imm & m) : (64'(vb >> (i * w)) & m);
                vr |= 128'(lane_eval(wd.code, w, x, y)) << (i * w);
            end
        end else if (wd.code <= OP_SMINP) begin
            case (wd.code)
                OP_ADDP:  base = OP_ADD;
                OP_UMAXP: base = OP_UMAX;
                OP_SMAXP: base = OP_SMAX;
                OP_UMINP: base = OP_UMIN;
                default:  base = OP_SMIN;
            endcase
            half = n / 2;
            if (half == 0) begin
                r.bad = 1'b1;
            end else begin
                // first vector's pairs fill the lower lanes, second vector's the upper
                for (int i = 0; i < half; i++) begin
                    x  = lane_eval(base, w, 64'(va >> (2 * i * w)) & m,
                                   64'(va >> ((2 * i + 1) * w)) & m);
                    y  = lane_eval(base, w, 64'(vb >> (2 * i * w)) & m,
                                   64'(vb >> ((2 * i + 1) * w)) & m);
                    vr |= 128'(x) << (i * w);
                    vr |= 128'(y) << ((half + i) * w);
                end
            end
        end else if (wd.code == OP_DUP) begin
            for (int i = 0; i < n; i++) begin
                vr |= 128'(wd.gp & m) << (i * w);
            end
        end else if (wd.code == OP_UMOV_HI) begin
            vr = {64'd0, wd.a_hi};
        end else if (wd.code == OP_INS_HI) begin
            vr = {wd.gp, wd.a_lo};
        end else begin
            r.bad = 1'b1;
        end
        if (!wd.wide && wd.code != OP_INS_HI) begin
            vr[127:64] = '0;
        end
        r.lo = vr[63:0];
        r.hi = vr[127:64];
        return r;
    endfunction

    // Whole-word extremes, per-lane extremes mixed, or plain random bits.
    function automatic logic [63:0] pick_operand(input logic [1:0] lsz);
        logic [63:0] m;
        logic [63:0] v;
        logic [63:0] lane;
        int unsigned w;
        w = 8 << lsz;
        m = lane_mask_of(w);
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2, 3: begin
                v = '0;
                for (int k = 0; k < 64; k += w) begin
                    case ($urandom_range(0, 5))
                        0:       lane = '0;
                        1:       lane = m;
                        2:       lane = (m >> 1) + 64'd1;
                        3:       lane = m >> 1;
                        4:       lane = 64'd1;
                        default: lane = {$urandom, $urandom} & m;
                    endcase
                    v |= lane << k;
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_simd_word random_word();
        t_simd_word  wd;
        int unsigned w;
        int unsigned p;
        int unsigned k;
        p       = $urandom_range(0, 99);
        wd.code = (p < 4) ? 5'($urandom_range(OP_INS_HI + 1, CODE_MAX))
                          : 5'($urandom_range(OP_ORR, OP_INS_HI));
        wd.lsz  = 2'($urandom_range(LS_8, LS_64));
        wd.wide = 1'($urandom_range(0, 1));
        wd.a_lo = pick_operand(wd.lsz);
        wd.a_hi = pick_operand(wd.lsz);
        wd.b_lo = pick_operand(wd.lsz);
        wd.b_hi = pick_operand(wd.lsz);
        wd.gp   = pick_operand(wd.lsz);
        wd.imm  = pick_operand(wd.lsz);
        w       = 8 << wd.lsz;
        p       = $urandom_range(0, 99);
        if (p < 15) begin
            // equal operands so the equality compares also come out true
            wd.b_lo = wd.a_lo;
            wd.b_hi = wd.a_hi;
        end else if (p < 30) begin
            // immediate matches one lane; bits above the lane stay random
            k      = w * $urandom_range(0, 64 / w - 1);
            wd.imm = (wd.imm & ~lane_mask_of(w)) | ((wd.a_lo >> k) & lane_mask_of(w));
        end
        return wd;
    endfunction

    function automatic int pick_gap(input int zero_pct);
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < zero_pct) begin
            return 0;
        end else if (p < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    task automatic queue_word(input logic [4:0] code, input logic [1:0] lsz, input logic wide,
                              input logic [63:0] a_lo, input logic [63:0] a_hi,
                              input logic [63:0] b_lo, input logic [63:0] b_hi,
                              input logic [63:0] gp, input logic [63:0] imm);
        t_simd_word wd;
        wd = '{code, lsz, wide, a_lo, a_hi, b_lo, b_hi, gp, imm};
        pending_words.push_back(wd);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        if (mismatches < 100) begin
            $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want_v);
        end
        mismatches++;
    endtask

    // Sender: hold a word until taken, then idle for a random gap.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid   <= 1'b0;
            send_gap       <= 0;
            send_calm      <= 0;
            words_accepted <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(vector_alu_predict(offered_word));
                words_accepted <= words_accepted + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0 || pending_words.size() == 0) begin
                    req_ch.valid <= 1'b0;
                    if (send_gap > 0) begin
                        send_gap <= send_gap - 1;
                    end
                end else begin
                    offered_word = pending_words.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.req_type     <= offered_word.code;
                    req_ch.lane_size    <= offered_word.lsz;
                    req_ch.full_width   <= offered_word.wide;
                    req_ch.first_low    <= offered_word.a_lo;
                    req_ch.first_high   <= offered_word.a_hi;
                    req_ch.second_low   <= offered_word.b_lo;
                    req_ch.second_high  <= offered_word.b_hi;
                    req_ch.scalar_value <= offered_word.gp;
                    req_ch.compare_imm  <= offered_word.imm;
                    if (send_calm > 0) begin
                        send_gap  <= 0;
                        send_calm <= send_calm - 1;
                    end else if ($urandom_range(0, 99) < 3) begin
                        send_gap  <= 0;
                        send_calm <= $urandom_range(20, 60);
                    end else begin
                        send_gap <= pick_gap(65);
                    end
                end
            end
        end
    end

    // Receiver: check each result against the oldest prediction, stall at random.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_stall   <= 0;
            recv_calm    <= 0;
            results_seen <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result_low", rsp_ch.result_low, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_ch.result_low !== want.lo) begin
                        report_mismatch("result_low", rsp_ch.result_low, want.lo);
                    end
                    if (rsp_ch.result_high !== want.hi) begin
                        report_mismatch("result_high", rsp_ch.result_high, want.hi);
                    end
                    if (rsp_ch.bad_combination !== want.bad) begin
                        report_mismatch("bad_combination", 64'(rsp_ch.bad_combination),
                                        64'(want.bad));
                    end
                end
            end
            if (!hold_done && results_seen == HOLD_AT) begin
                // long hold-off: let the block fill and push back on the sender
                rsp_ch.ready <= 1'b0;
                recv_stall   <= HOLD_CYCLES;
                hold_done    <= 1'b1;
            end else if (recv_stall > 0) begin
                rsp_ch.ready <= 1'b0;
                recv_stall   <= recv_stall - 1;
            end else if (recv_calm > 0) begin
                rsp_ch.ready <= 1'b1;
                recv_calm    <= recv_calm - 1;
            end else if ($urandom_range(0, 99) < 2) begin
                rsp_ch.ready <= 1'b1;
                recv_calm    <= $urandom_range(20, 60);
            end else begin
                g = pick_gap(85);
                rsp_ch.ready <= (g == 0);
                recv_stall   <= (g == 0) ? 0 : g - 1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        rst_n               = 1'b0;
        mismatches          = 0;
        idle_cycles         = 0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = '0;
        req_ch.lane_size    = '0;
        req_ch.full_width   = 1'b0;
        req_ch.first_low    = '0;
        req_ch.first_high   = '0;
        req_ch.second_low   = '0;
        req_ch.second_high  = '0;
        req_ch.scalar_value = '0;
        req_ch.compare_imm  = '0;
        rsp_ch.ready        = 1'b0;

        // every operation once, lane sizes and widths rotating, operands at the lane limits
        for (int c = OP_ORR; c <= OP_INS_HI; c++) begin
            queue_word(5'(c), 2'(c % 4), (c % 3) != 0,
                       64'h8000_7FFF_FF01_0080, 64'hFFFF_FFFF_0000_0000,
                       64'h7FFF_8000_0180_FF7F, 64'h0000_0000_FFFF_FFFF,
                       64'hFEDC_BA98_7654_3210, 64'hFFFF_FFFF_FFFF_FF80);
        end
        // pairwise add with one 64-bit lane has no pair
        queue_word(OP_ADDP, LS_64, 1'b0, '1, '1, 64'd5, 64'd7, '0, '0);
        // dup of a 64-bit lane into the narrow form
        queue_word(OP_DUP, LS_64, 1'b0, '0, '0, '0, '0, '1, '0);
        // unused operation code
        queue_word(CODE_MAX, LS_8, 1'b1, '1, '1, '1, '1, '1, '1);
        // add with all-ones lanes wraps
        queue_word(OP_ADD, LS_8, 1'b1, '1, '1, '1, '1, '1, '1);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pending_words.push_back(random_word());
        end
        total_words = pending_words.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted != total_words || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/psa_pkg.sv
hdl/psa_req_if.sv
hdl/psa_rsp_if.sv
hdl/psa_exec.sv
hdl/packed_simd_integer_alu_core.sv
dv/packed_simd_integer_alu_core_test.sv
